[hdl/tlwd_pkg.sv]
// ----------------------------------------------------------------------------
// tlwd_pkg: shared types and constants for the task liveness watchdog feeder
// Holds opcode and status codes, sequencer states, field widths and the
// result word of the shared delta compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tlwd_pkg;

    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 16;
    localparam int OP_W     = 2;
    localparam int TASK_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam int TASK_COUNT_DEF = 8;

    // Reset values of the configuration registers
    localparam logic [LIMIT_W-1:0] TASK_WINDOW_RST = LIMIT_W'(500);
    localparam logic [LIMIT_W-1:0] FEED_PERIOD_RST = LIMIT_W'(100);

    // Stream word widths (padded to whole bytes)
    localparam int S_TDATA_W = 40;   // task_index, now_ms
    localparam int M_TDATA_W = 8;    // feed, stall_seen, status

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TASK_WINDOW = 1'b0,
        REG_FEED_PERIOD = 1'b1
    } t_cfg_reg;

    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 2'd0,
        OP_ENABLE = 2'd1,
        OP_REPORT = 2'd2,
        OP_POLL   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOT_INIT = 2'd1,
        ST_BAD_TASK = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_THROTTLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Result of one pass through the shared delta compare unit
    typedef struct packed {
        logic below;   // (a - b) <  limit
        logic above;   // (a - b) >  limit
    } t_cmp_res;

    typedef struct packed {
        logic    feed;
        logic    stall_seen;
        t_status status;
    } t_result;

endpackage

`default_nettype wire

[hdl/tlwd_delta_cmp.sv]
// ----------------------------------------------------------------------------
// tlwd_delta_cmp: shared elapsed-time compare unit
// Takes a wrapping time difference and compares it against a 16-bit limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tlwd_delta_cmp (
    input  wire logic [tlwd_pkg::TIME_W-1:0]  i_now,
    input  wire logic [tlwd_pkg::TIME_W-1:0]  i_stamp,
    input  wire logic [tlwd_pkg::LIMIT_W-1:0] i_limit,
    output tlwd_pkg::t_cmp_res                o_res
);
    import tlwd_pkg::*;

    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] limit_ext;

    // Difference wraps modulo 2^32
    assign delta     = i_now - i_stamp;
    assign limit_ext = {{(TIME_W-LIMIT_W){1'b0}}, i_limit};

    assign o_res.below = (delta < limit_ext);
    assign o_res.above = (delta > limit_ext);

endmodule

`default_nettype wire

[hdl/task_liveness_watchdog_feeder.sv]
// ----------------------------------------------------------------------------
// task_liveness_watchdog_feeder: windowed task liveness watchdog supervisor
// Tracks TASK_COUNT tasks and decides when the hardware watchdog is fed.
//
// Input stream: tuser carries the opcode (init, enable, report, poll), tdata
// carries the task index and the current millisecond time. Every word gives
// exactly one result word on the output stream: feed, stall_seen, status.
// Configuration: plain write port, index 0 task window, index 1 feed period;
// write only while the block is idle.
//
// State path, from input acceptance to result held on the output register:
//   enable/report/rejected word : IDLE, DONE
//   init                        : IDLE, INIT (timestamp sweep), DONE
//   poll, throttled             : IDLE, THROTTLE, DONE
//   poll, full scan             : IDLE, THROTTLE, SCAN over every task, DRAIN, DONE
// The poll scan visits one stored timestamp per cycle through a single
// elapsed-time compare unit, which also does the throttle check; the init
// sweep writes one timestamp per cycle through the single memory write port.
// One word is in work at a time: tready is high only while idle.
//
// Reset clears the task enables, the last-feed time and the initialized flag
// and loads the register defaults (window 500 ms, period 100 ms); timestamps
// are undefined until the first init. A stalled receiver holds the result in
// the output register; the next input word is still taken and worked on, and
// its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module task_liveness_watchdog_feeder #(
    parameter int TASK_COUNT = tlwd_pkg::TASK_COUNT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [tlwd_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [tlwd_pkg::LIMIT_W-1:0]     i_cfg_wdata,
    // Input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] task_index, [39:8] now_ms
    input  wire logic [tlwd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  wire logic [tlwd_pkg::OP_W-1:0]        s_axis_tuser,
    // Output stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] feed, [1] stall_seen, [3:2] status, [7:4] zero
    output logic [tlwd_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
    import tlwd_pkg::*;

    localparam int AW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam logic [TASK_W:0]  TASK_LIMIT = (TASK_W+1)'(TASK_COUNT);
    localparam logic [AW-1:0]    LAST_IDX   = AW'(TASK_COUNT - 1);

    // ---------------------------------------------------------------- state
    t_state                 r_state,     n_state;
    logic [LIMIT_W-1:0]     r_window,    n_window;
    logic [LIMIT_W-1:0]     r_period,    n_period;
    logic [TASK_COUNT-1:0]  r_task_en,   n_task_en;
    logic [TIME_W-1:0]      r_last_feed, n_last_feed;
    logic                   r_init,      n_init;
    logic [TIME_W-1:0]      r_now,       n_now;
    logic [AW-1:0]          r_idx,       n_idx;
    logic                   r_rd_valid,  n_rd_valid;
    logic                   r_rd_en,     n_rd_en;
    logic                   r_stale,     n_stale;
    t_result                r_res,       n_res;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out,       n_out;

    // Timestamp store, read data registered
    logic [TIME_W-1:0]      r_mem [TASK_COUNT];
    logic [TIME_W-1:0]      r_rd_data;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [TIME_W-1:0]      mem_wdata;

    // Unpacked input word
    t_opcode                in_op;
    logic [TASK_W-1:0]      in_task;
    logic [TIME_W-1:0]      in_now;
    logic                   in_range;
    logic                   accept;

    // Shared compare unit
    logic [TIME_W-1:0]      cmp_stamp;
    logic [LIMIT_W-1:0]     cmp_limit;
    t_cmp_res               cmp_res;
    logic                   stale_hit;
    logic                   stale_all;

    assign in_op    = t_opcode'(s_axis_tuser);
    assign in_task  = s_axis_tdata[TASK_W-1:0];
    assign in_now   = s_axis_tdata[TASK_W +: TIME_W];
    assign in_range = ({1'b0, in_task} < TASK_LIMIT);

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-4){1'b0}}, r_out.status, r_out.stall_seen, r_out.feed};

    // Throttle check against the last feed, otherwise the scanned timestamp
    assign cmp_stamp = (r_state == S_THROTTLE) ? r_last_feed : r_rd_data;
    assign cmp_limit = (r_state == S_THROTTLE) ? r_period : r_window;

    tlwd_delta_cmp u_cmp (
        .i_now   (r_now),
        .i_stamp (cmp_stamp),
        .i_limit (cmp_limit),
        .o_res   (cmp_res)
    );

    assign stale_hit = r_rd_valid && r_rd_en && cmp_res.above;
    assign stale_all = r_stale || stale_hit;

    // Memory write: init sweep, or the addressed task on enable/report
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_now;
        if (r_state == S_INIT) begin
            mem_we = 1'b1;
        end else if (accept && r_init && in_range
                     && (in_op == OP_ENABLE || in_op == OP_REPORT)) begin
            mem_we    = 1'b1;
            mem_waddr = in_task[AW-1:0];
            mem_wdata = in_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_idx];
    end

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_period    = r_period;
        n_task_en   = r_task_en;
        n_last_feed = r_last_feed;
        n_init      = r_init;
        n_now       = r_now;
        n_idx       = r_idx;
        n_rd_valid  = 1'b0;
        n_rd_en     = r_rd_en;
        n_stale     = r_stale;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // Drop the result word once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_TASK_WINDOW: n_window = i_cfg_wdata;
                REG_FEED_PERIOD: n_period = i_cfg_wdata;
                default:         n_window = r_window;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now = in_now;
                    n_res = '{feed: 1'b0, stall_seen: 1'b0, status: ST_OK};
                    n_idx = '0;
                    if (in_op == OP_INIT) begin
                        n_task_en   = '0;
                        n_last_feed = in_now;
                        n_init      = 1'b1;
                        n_res.feed  = 1'b1;
                        n_state     = S_INIT;
                    end else if (!r_init) begin
                        n_res.status = ST_NOT_INIT;
                        n_state      = S_DONE;
                    end else begin
                        case (in_op)
                            OP_ENABLE, OP_REPORT: begin
                                if (!in_range) begin
                                    n_res.status = ST_BAD_TASK;
                                end else if (in_op == OP_ENABLE) begin
                                    n_task_en[in_task[AW-1:0]] = 1'b1;
                                end
                                n_state = S_DONE;
                            end
                            OP_POLL: begin
                                n_state = S_THROTTLE;
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
            end
            S_INIT: begin
                // Stamp one task per cycle with the init time
                n_idx = r_idx + AW'(1);
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_DONE;
                end
            end
            S_THROTTLE: begin
                if (cmp_res.below) begin
                    n_state = S_DONE;
                end else begin
                    n_stale = 1'b0;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue read of r_idx, check the word read last cycle
                n_rd_valid = 1'b1;
                n_rd_en    = r_task_en[r_idx];
                n_stale    = stale_all;
                n_idx      = r_idx + AW'(1);
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (stale_all) begin
                    n_res.stall_seen = 1'b1;
                end else begin
                    n_res.feed  = 1'b1;
                    n_last_feed = r_now;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= TASK_WINDOW_RST;
            r_period    <= FEED_PERIOD_RST;
            r_task_en   <= '0;
            r_last_feed <= '0;
            r_init      <= 1'b0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_period    <= n_period;
            r_task_en   <= n_task_en;
            r_last_feed <= n_last_feed;
            r_init      <= n_init;
            r_idx       <= n_idx;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now   <= n_now;
        r_rd_en <= n_rd_en;
        r_stale <= n_stale;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // ----------------------------------------------------------- assertions
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted word did not start a sequence");

    a_rd_valid_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("scan read pending outside the scan");

    a_no_enable_before_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init |-> (r_task_en == '0))
        else $error("task enabled before init");

    a_feed_xor_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.feed && r_out.stall_seen))
        else $error("result both feeds and reports a stall");

    a_poll_feed_stamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && !stale_all) |=> (r_last_feed == $past(r_now)))
        else $error("poll feed did not update the last feed time");

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the task liveness watchdog feeder
// A scoreboard class predicts feed, stall_seen and status for every word the
// block accepts and checks each result word against the oldest prediction.
// The stimulus is a directed opening followed by random phases. Each phase has
// its own window and period setting and one of four patterns of sender and
// receiver idling.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlwd_pkg::*;

    localparam int TASK_COUNT    = TASK_COUNT_DEF;
    // Longest block latency is a full poll scan; allow a margin beyond it
    localparam int SETTLE_CYCLES = TASK_COUNT + 8;
    // Cycles with no word moving on either side before the run is abandoned
    localparam int STALL_LIMIT   = 4000;
    localparam int WORDS_PER_PHASE = 100;
    localparam int PHASES        = 6;
    localparam int HOLD_OFF_CYCLES = 300;

    // ------------------------------------------------------------------------
    // Predicts the watchdog feed decision and holds the results still owed
    // ------------------------------------------------------------------------
    class feed_scoreboard;
        bit                 enabled [TASK_COUNT];
        logic [TIME_W-1:0]  last_alive [TASK_COUNT];
        logic [TIME_W-1:0]  last_feed;
        bit                 started;
        logic [LIMIT_W-1:0] window;
        logic [LIMIT_W-1:0] period;
        t_result            due_verdicts [$];
        int unsigned        error_count;

        function new();
            foreach (enabled[i]) begin
                enabled[i]    = 1'b0;
                last_alive[i] = '0;
            end
            last_feed   = '0;
            started     = 1'b0;
            window      = TASK_WINDOW_RST;
            period      = FEED_PERIOD_RST;
            error_count = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [LIMIT_W-1:0] value);
            if (idx == REG_TASK_WINDOW) begin
                window = value;
            end else begin
                period = value;
            end
        endfunction

        // Apply one accepted word to the shadow state and queue its result
        function void note_word(t_opcode op, logic [TASK_W-1:0] task_idx,
                                logic [TIME_W-1:0] now);
            t_result           v;
            logic [TIME_W-1:0] elapsed;
            bit                stale;
            v.feed       = 1'b0;
            v.stall_seen = 1'b0;
            v.status     = ST_OK;
            if (op == OP_INIT) begin
                // Re-init is always allowed: disable and restamp everything
                foreach (enabled[i]) begin
                    enabled[i]    = 1'b0;
                    last_alive[i] = now;
                end
                last_feed = now;
                started   = 1'b1;
                v.feed    = 1'b1;
            end else if (!started) begin
                v.status = ST_NOT_INIT;
            end else if (op == OP_ENABLE || op == OP_REPORT) begin
                if (task_idx >= TASK_COUNT) begin
                    v.status = ST_BAD_TASK;
                end else begin
                    if (op == OP_ENABLE) begin
                        enabled[task_idx] = 1'b1;
                    end
                    last_alive[task_idx] = now;
                end
            end else begin
                // Poll: throttle first, then scan the enabled tasks
                elapsed = now - last_feed;
                if (elapsed >= {16'd0, period}) begin
                    stale = 1'b0;
                    foreach (enabled[i]) begin
                        if (enabled[i] && (now - last_alive[i]) > {16'd0, window}) begin
                            stale = 1'b1;
                        end
                    end
                    if (stale) begin
                        v.stall_seen = 1'b1;
                    end else begin
                        v.feed    = 1'b1;
                        last_feed = now;
                    end
                end
            end
            due_verdicts.push_back(v);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
            error_count++;
        endtask

        // Compare one result word with the oldest outstanding prediction
        task check_verdict(logic [M_TDATA_W-1:0] word);
            t_result want;
            if (due_verdicts.size() == 0) begin
                report_mismatch("result word with nothing pending", word, 0);
            end else begin
                want = due_verdicts.pop_front();
                if (word[0] !== want.feed) begin
                    report_mismatch("feed", word[0], want.feed);
                end
                if (word[1] !== want.stall_seen) begin
                    report_mismatch("stall_seen", word[1], want.stall_seen);
                end
                if (word[3:2] !== want.status) begin
                    report_mismatch("status", word[3:2], want.status);
                end
                if (word[7:4] !== 4'd0) begin
                    report_mismatch("padding bits", word[7:4], 0);
                end
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr = '0;
    logic [LIMIT_W-1:0]     i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [7:0] task_index, [39:8] now_ms
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    // [1:0] opcode
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] feed, [1] stall_seen, [3:2] status, [7:4] zero
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    feed_scoreboard   board;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      hold_cycles = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    task_liveness_watchdog_feeder #(
        .TASK_COUNT(TASK_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: stall at random, or hold off entirely while a hold-off runs
    always @(negedge i_clk) begin
        m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Count down a receiver hold-off, one cycle per rising edge
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Sample both handshakes at the rising edge; note inputs before checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_word(t_opcode'(s_axis_tuser), s_axis_tdata[TASK_W-1:0],
                                s_axis_tdata[S_TDATA_W-1:TASK_W]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_verdict(m_axis_tdata);
            end
        end
    end

    // Abandon the run once no word has moved for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench: done, errors");
        $finish;
    end

    // Offer one word after a random idle gap and hold it until it is taken.
    // tvalid stays high afterwards so back-to-back words see no bubble.
    task automatic offer_word(t_opcode op, logic [TASK_W-1:0] task_idx,
                              logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {now, task_idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop the sender, wait for every owed result, then let the block go idle
    task automatic settle_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.due_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        board.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Advance time by a step that tends to land on the period and window edges
    function automatic logic [TIME_W-1:0] next_gap();
        logic [TIME_W-1:0] w;
        logic [TIME_W-1:0] p;
        w = {16'd0, board.window};
        p = {16'd0, board.period};
        case ($urandom_range(9))
            0:       next_gap = '0;
            1, 2:    next_gap = $urandom_range(p + 1);
            3:       next_gap = p;
            4:       next_gap = w;
            5:       next_gap = w + 1;
            6, 7:    next_gap = $urandom_range(w / 4 + 1);
            8:       next_gap = $urandom_range(2 * w + 2);
            default: next_gap = 1;
        endcase
    endfunction

    // Mostly well-formed traffic: enables, reports to live tasks and polls,
    // with an occasional re-init and some wild words mixed in
    task automatic offer_random_word();
        int unsigned       pick;
        logic [TASK_W-1:0] idx;
        pick = $urandom_range(99);
        clock_ms += next_gap();
        idx = ($urandom_range(99) < 15) ? TASK_W'($urandom)
                                        : TASK_W'($urandom_range(TASK_COUNT - 1));
        if (pick < 4) begin
            offer_word(OP_INIT, TASK_W'($urandom), clock_ms);
        end else if (pick < 20) begin
            offer_word(OP_ENABLE, idx, clock_ms);
        end else if (pick < 55) begin
            offer_word(OP_REPORT, idx, clock_ms);
        end else if (pick < 95) begin
            offer_word(OP_POLL, TASK_W'($urandom), clock_ms);
        end else begin
            offer_word(t_opcode'($urandom_range(3)), TASK_W'($urandom), $urandom);
        end
    endtask

    initial begin
        int unsigned       phase;
        int unsigned       n;
        logic [TIME_W-1:0] t0;
        logic [LIMIT_W-1:0] win;
        logic [LIMIT_W-1:0] per;

        board = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset register values (window 500, period 100).
        // Every word before the first init must be refused as not initialised.
        offer_word(OP_POLL, 8'd0, 32'd0);
        offer_word(OP_ENABLE, 8'd3, 32'd5);
        offer_word(OP_REPORT, 8'hFF, 32'hFFFF_FFFF);
        // Start just below the top of the time range so later steps wrap past zero
        t0 = 32'hFFFF_FF00;
        offer_word(OP_INIT, 8'hFF, t0);
        offer_word(OP_POLL, 8'd0, t0 + 99);              // throttled
        offer_word(OP_ENABLE, 8'd0, t0 + 10);
        offer_word(OP_ENABLE, 8'(TASK_COUNT - 1), t0 + 20);
        offer_word(OP_ENABLE, 8'(TASK_COUNT), t0 + 25);  // index out of range
        offer_word(OP_REPORT, 8'hFF, t0 + 28);           // index out of range
        offer_word(OP_REPORT, 8'd5, t0 + 30);            // task not enabled
        offer_word(OP_POLL, 8'hAA, t0 + 100);            // exactly one period: feeds
        offer_word(OP_POLL, 8'd0, t0 + 150);             // throttled again
        offer_word(OP_REPORT, 8'd0, t0 + 500);           // time wraps past zero here
        offer_word(OP_POLL, 8'd0, t0 + 520);             // last task exactly at window
        offer_word(OP_POLL, 8'd0, t0 + 621);             // last task past its window
        offer_word(OP_REPORT, 8'(TASK_COUNT - 1), t0 + 630);
        offer_word(OP_POLL, 8'h55, t0 + 640);
        offer_word(OP_INIT, 8'd0, 32'h0000_1234);        // repeated init
        offer_word(OP_POLL, 8'd0, 32'h0000_1234 + 100);  // no task enabled: feeds
        offer_word(OP_POLL, 8'd0, 32'h0000_1234 + 101);
        offer_word(OP_ENABLE, 8'd128, 32'h0000_2000);
        offer_word(OP_ENABLE, 8'd4, 32'h0000_2000);
        offer_word(OP_POLL, 8'd0, 32'h0000_2000 + 501);  // stale: stall seen

        clock_ms = $urandom;
        for (phase = 0; phase < PHASES; phase++) begin
            settle_block();
            case (phase)
                0: begin
                    win = TASK_WINDOW_RST;
                    per = FEED_PERIOD_RST;
                end
                1: begin
                    win = 16'hFFFF;
                    per = 16'hFFFF;
                end
                2: begin
                    win = 16'd1;
                    per = 16'd1;
                end
                3: begin
                    // Zero window needs a report in the same millisecond;
                    // zero period never throttles. Also start near the top of the time range.
                    win = 16'd0;
                    per = 16'd0;
                    clock_ms = 32'hFFFF_F000;
                end
                4: begin
                    win = LIMIT_W'($urandom);
                    per = LIMIT_W'($urandom);
                end
                default: begin
                    win = LIMIT_W'($urandom_range(2000, 1));
                    per = LIMIT_W'($urandom_range(500, 1));
                end
            endcase
            write_reg(REG_TASK_WINDOW, win);
            write_reg(REG_FEED_PERIOD, per);

            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 54;
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase

            // Hold the receiver off for a long stretch while words keep coming,
            // so the output register fills and the input side backs up
            if (phase == 0) begin
                hold_cycles = HOLD_OFF_CYCLES;
            end

            offer_word(OP_INIT, TASK_W'($urandom), clock_ms);
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                // Pause the sender mid-phase until every owed result is back
                if (phase == 2 && n == WORDS_PER_PHASE / 2) begin
                    settle_block();
                end
                offer_random_word();
            end
        end

        settle_block();
        if (board.error_count == 0 && board.due_verdicts.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
